[src/flcu_pkg.sv]
// Package for the free-look camera update block: widths, codes, sequencer types
// and the small arithmetic helpers used by the datapath.
// No dependencies.
package flcu_pkg;

	localparam int ANGLE_BITS      = 24;
	localparam int VEC_FRAC_BITS   = 14;
	localparam int QUARTER_BITS    = ANGLE_BITS - 2;
	localparam int VEC_W           = VEC_FRAC_BITS + 3;
	localparam int MUL_A_W         = (VEC_W > 18) ? VEC_W : 18;
	localparam int MUL_B_W         = 34;
	localparam int MUL_P_W         = MUL_A_W + MUL_B_W;
	localparam int DELTA_W         = 36;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 20;
	localparam int IN_W            = 48;
	localparam int OUT_W           = 192;

	localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 8'd1;

	localparam logic [1:0] KEY_FORWARD = 2'd0;
	localparam logic [1:0] KEY_LEFT    = 2'd1;
	localparam logic [1:0] KEY_BACK    = 2'd2;
	localparam logic [1:0] KEY_RIGHT   = 2'd3;

	// sine argument source
	localparam logic [1:0] SEL_SIN_YAW   = 2'd0;
	localparam logic [1:0] SEL_COS_YAW   = 2'd1;
	localparam logic [1:0] SEL_SIN_PITCH = 2'd2;
	localparam logic [1:0] SEL_COS_PITCH = 2'd3;

	localparam logic [ANGLE_BITS-1:0] YAW_RESET = ANGLE_BITS'(3) << QUARTER_BITS;
	localparam logic [ANGLE_BITS-1:0] QUARTER   = ANGLE_BITS'(1) << QUARTER_BITS;

	localparam int SIN_RSH  = (VEC_FRAC_BITS < 16) ? 16 - VEC_FRAC_BITS : 0;
	localparam int SIN_LSH  = (VEC_FRAC_BITS > 16) ? VEC_FRAC_BITS - 16 : 0;
	localparam int SIN_HALF = (VEC_FRAC_BITS < 16) ? (1 << (15 - VEC_FRAC_BITS)) : 0;
	localparam int X_RSH    = (QUARTER_BITS >= 16) ? QUARTER_BITS - 16 : 0;
	localparam int X_LSH    = (QUARTER_BITS >= 16) ? 0 : 16 - QUARTER_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WB,
		ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_YAW,
		OP_PITCH,
		OP_SIN_SQ,
		OP_SIN_C1,
		OP_SIN_C2,
		OP_SIN_R,
		OP_FX,
		OP_FZ,
		OP_UX,
		OP_UZ,
		OP_UY_A,
		OP_UY_B,
		OP_STEP,
		OP_D_FX,
		OP_D_FY,
		OP_D_FZ,
		OP_D_RX,
		OP_D_RZ,
		OP_MOVE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] sel;
		logic [1:0] mv;
		logic       issue;
		logic       wb;
		logic       load_out;
	} ctl_t;

	// {negate, x}: x is the Q16 fraction of the quadrant, mirrored in odd quadrants
	function automatic logic [17:0] sine_arg(input logic [ANGLE_BITS-1:0] a);
		logic [QUARTER_BITS+16:0] wide;
		logic [16:0] x;
		wide = {17'b0, a[QUARTER_BITS-1:0]};
		x = 17'((wide << X_LSH) >> X_RSH);
		if (a[QUARTER_BITS])
			x = 17'h10000 - x;
		return {a[ANGLE_BITS-1], x};
	endfunction

	function automatic logic signed [VEC_W-1:0] sine_mag(input logic [18:0] r, input logic neg);
		logic [23:0] m;
		logic signed [VEC_W-1:0] v;
		m = ((24'(r) + 24'(SIN_HALF)) >> SIN_RSH) << SIN_LSH;
		v = VEC_W'(signed'({1'b0, m}));
		return neg ? -v : v;
	endfunction

	// round half up to VEC_FRAC_BITS
	function automatic logic signed [MUL_P_W-1:0] rnd_vec(input logic signed [MUL_P_W-1:0] v);
		logic signed [MUL_P_W-1:0] half;
		half = MUL_P_W'(1) << (VEC_FRAC_BITS - 1);
		return (v + half) >>> VEC_FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
		input logic signed [DELTA_W-1:0] d);
		logic signed [DELTA_W:0] s;
		s = (DELTA_W+1)'(p) + (DELTA_W+1)'(d);
		if (s > (DELTA_W+1)'(32'sh7FFFFFFF))
			return 32'sh7FFFFFFF;
		else if (s < -(DELTA_W+1)'(33'sh080000000))
			return 32'sh80000000;
		else
			return 32'(s);
	endfunction

endpackage

[src/flcu_mul.sv]
// Shared signed multiplier of the camera update block, product registered.
// Depends on flcu_pkg.
module flcu_mul import flcu_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		if (en)
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

[src/flcu_ctrl.sv]
// Sequencer of the camera update block: walks the operation list, each
// operation in an issue state, then a write back state. Depends on flcu_pkg.
module flcu_ctrl import flcu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic out_free,
	output logic ready,
	output ctl_t ctl
);

	state_t     state_q, state_d;
	op_t        op_q, op_d;
	logic [1:0] sel_q, sel_d;
	logic [1:0] mv_q, mv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_YAW;
			sel_q   <= 2'd0;
			mv_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			sel_q   <= sel_d;
			mv_q    <= mv_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		sel_d        = sel_q;
		mv_d         = mv_q;
		ctl.op       = op_q;
		ctl.sel      = sel_q;
		ctl.mv       = mv_q;
		ctl.issue    = 1'b0;
		ctl.wb       = 1'b0;
		ctl.load_out = 1'b0;
		ready        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = ST_ISSUE;
					op_d    = OP_YAW;
					sel_d   = 2'd0;
					mv_d    = 2'd0;
				end
			end
			ST_ISSUE: begin
				ctl.issue = 1'b1;
				state_d   = ST_WB;
			end
			ST_WB: begin
				ctl.wb  = 1'b1;
				state_d = ST_ISSUE;
				case (op_q)
					OP_SIN_R: begin
						if (sel_q == SEL_COS_PITCH) begin
							op_d  = OP_FX;
							sel_d = 2'd0;
						end else begin
							op_d  = OP_SIN_SQ;
							sel_d = sel_q + 2'd1;
						end
					end
					OP_MOVE: begin
						if (mv_q == KEY_RIGHT)
							state_d = ST_DONE;
						else
							mv_d = mv_q + 2'd1;
					end
					default: op_d = op_t'(op_q + 5'd1);
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
		endcase
	end

endmodule

[src/free_look_camera_update.sv]
// Top level of the free-look camera update block: input and config registers,
// camera state, operand selection and write back. Depends on flcu_pkg,
// flcu_ctrl and flcu_mul.
//
// Usage:
//   s_axis carries one frame per transaction: mouse deltas, elapsed time and
//   the four movement keys. m_axis returns one transaction per frame with the
//   new position (Q16.16) and the front and up vectors (Q2.14).
//   cfg writes turn_speed (index 0) or move_speed (index 1); other indexes are
//   dropped. cfg_ready is always high; write only while the block is idle.
// Sequence:
//   A frame runs as 34 operations, each issued to the one shared multiplier
//   and then written back, namely two angle updates, four sines of four
//   multiplies each, six vector products, the step product, five move deltas
//   and four saturating moves, after which the output register is loaded.
//   s_axis_tready stays low for that whole time, so the block takes no new
//   frame until it has finished the current one and returned to idle.
//   The result sits in an output register; the next frame is accepted while it
//   waits. If the receiver stalls, hold the finished frame in the sequencer
//   until the output register frees up.
// Reset:
//   arst_n clears the handshake state, sets yaw to minus ninety degrees, pitch
//   and position to zero, and the speeds to their defaults.
module free_look_camera_update import flcu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// mouse_dx, mouse_dy, elapsed_time, key_forward, key_left, key_back, key_right
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// pos_x, pos_y, pos_z, front_x, front_y, front_z, up_x, up_y, up_z
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_t ctl;
	logic start, out_free, out_valid_q;

	// frame fields, captured on acceptance
	logic signed [11:0] dx_q, dy_q;
	logic [15:0]        et_q;
	logic [3:0]         keys_q;

	// configuration
	logic [19:0] ts_q;
	logic [15:0] ms_q;

	// camera state
	logic [ANGLE_BITS-1:0] yaw_q, pitch_q;
	logic signed [31:0]    pos_x_q, pos_y_q, pos_z_q;

	// working registers
	logic [16:0]                x2_q, t_q;
	logic signed [VEC_W-1:0]    sin_q [4];
	logic signed [VEC_W-1:0]    fx_q, fz_q, ux_q, uy_q, uz_q;
	logic signed [MUL_P_W-1:0]  acc_q;
	logic [31:0]                step_q;
	logic signed [DELTA_W-1:0]  d_fx_q, d_fy_q, d_fz_q, d_rx_q, d_rz_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	logic [ANGLE_BITS-1:0]   angle;
	logic [17:0]             arg;
	logic signed [VEC_W-1:0] sy, cy, sp, cp, rx, rz;
	logic signed [DELTA_W-1:0] mv_x, mv_y, mv_z;
	logic                    key;

	assign start     = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	flcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.ready    (s_axis_tready),
		.ctl      (ctl)
	);

	flcu_mul u_mul (
		.clk (clk),
		.en  (ctl.issue),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign sy = sin_q[SEL_SIN_YAW];
	assign cy = sin_q[SEL_COS_YAW];
	assign sp = sin_q[SEL_SIN_PITCH];
	assign cp = sin_q[SEL_COS_PITCH];
	// right = sign(cos pitch) * (-sin yaw, 0, cos yaw); zero counts as positive
	assign rx = cp[VEC_W-1] ? sy : -sy;
	assign rz = cp[VEC_W-1] ? -cy : cy;

	always_comb begin
		unique case (ctl.sel)
			SEL_SIN_YAW:   angle = yaw_q;
			SEL_COS_YAW:   angle = yaw_q + QUARTER;
			SEL_SIN_PITCH: angle = pitch_q;
			SEL_COS_PITCH: angle = pitch_q + QUARTER;
		endcase
	end
	assign arg = sine_arg(angle);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.op)
			OP_YAW: begin
				mul_a = MUL_A_W'(dx_q);
				mul_b = MUL_B_W'(ts_q);
			end
			OP_PITCH: begin
				mul_a = MUL_A_W'(dy_q);
				mul_b = MUL_B_W'(ts_q);
			end
			OP_SIN_SQ: begin
				mul_a = MUL_A_W'(arg[16:0]);
				mul_b = MUL_B_W'(arg[16:0]);
			end
			OP_SIN_C1: begin
				mul_a = MUL_A_W'(x2_q);
				mul_b = MUL_B_W'(17'd4639);
			end
			OP_SIN_C2: begin
				mul_a = MUL_A_W'(x2_q);
				mul_b = MUL_B_W'(t_q);
			end
			OP_SIN_R: begin
				mul_a = MUL_A_W'(arg[16:0]);
				mul_b = MUL_B_W'(t_q);
			end
			OP_FX: begin
				mul_a = MUL_A_W'(cy);
				mul_b = MUL_B_W'(cp);
			end
			OP_FZ: begin
				mul_a = MUL_A_W'(sy);
				mul_b = MUL_B_W'(cp);
			end
			OP_UX: begin
				mul_a = MUL_A_W'(rz);
				mul_b = MUL_B_W'(sp);
			end
			OP_UZ: begin
				mul_a = MUL_A_W'(rx);
				mul_b = MUL_B_W'(sp);
			end
			OP_UY_A: begin
				mul_a = MUL_A_W'(rz);
				mul_b = MUL_B_W'(fx_q);
			end
			OP_UY_B: begin
				mul_a = MUL_A_W'(rx);
				mul_b = MUL_B_W'(fz_q);
			end
			OP_STEP: begin
				mul_a = MUL_A_W'(ms_q);
				mul_b = MUL_B_W'(et_q);
			end
			OP_D_FX: begin
				mul_a = MUL_A_W'(fx_q);
				mul_b = MUL_B_W'(step_q);
			end
			OP_D_FY: begin
				mul_a = MUL_A_W'(sp);
				mul_b = MUL_B_W'(step_q);
			end
			OP_D_FZ: begin
				mul_a = MUL_A_W'(fz_q);
				mul_b = MUL_B_W'(step_q);
			end
			OP_D_RX: begin
				mul_a = MUL_A_W'(rx);
				mul_b = MUL_B_W'(step_q);
			end
			OP_D_RZ: begin
				mul_a = MUL_A_W'(rz);
				mul_b = MUL_B_W'(step_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// move deltas for the key in turn; released keys add nothing
	always_comb begin
		key  = keys_q[ctl.mv];
		mv_x = '0;
		mv_y = '0;
		mv_z = '0;
		unique case (ctl.mv)
			KEY_FORWARD: begin
				mv_x = d_fx_q;
				mv_y = d_fy_q;
				mv_z = d_fz_q;
			end
			KEY_LEFT: begin
				mv_x = -d_rx_q;
				mv_z = -d_rz_q;
			end
			KEY_BACK: begin
				mv_x = -d_fx_q;
				mv_y = -d_fy_q;
				mv_z = -d_fz_q;
			end
			KEY_RIGHT: begin
				mv_x = d_rx_q;
				mv_z = d_rz_q;
			end
		endcase
		if (!key) begin
			mv_x = '0;
			mv_y = '0;
			mv_z = '0;
		end
	end

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= 20'd9321;
			ms_q <= 16'd1311;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_TURN_SPEED)
				ts_q <= cfg_data[19:0];
			else if (cfg_index == REG_MOVE_SPEED)
				ms_q <= cfg_data[15:0];
		end
	end

	// frame capture
	always_ff @(posedge clk) begin
		if (start) begin
			dx_q   <= s_axis_tdata[11:0];
			dy_q   <= s_axis_tdata[23:12];
			et_q   <= s_axis_tdata[39:24];
			keys_q <= s_axis_tdata[43:40];
		end
	end

	// camera state: angles and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= YAW_RESET;
			pitch_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (ctl.wb) begin
			if (ctl.op == OP_YAW)
				yaw_q <= yaw_q + prod[ANGLE_BITS-1:0];
			if (ctl.op == OP_PITCH)
				pitch_q <= pitch_q + prod[ANGLE_BITS-1:0];
			if (ctl.op == OP_MOVE) begin
				pos_x_q <= sat_add(pos_x_q, mv_x);
				pos_y_q <= sat_add(pos_y_q, mv_y);
				pos_z_q <= sat_add(pos_z_q, mv_z);
			end
		end
	end

	// write back of the working registers
	always_ff @(posedge clk) begin
		if (ctl.wb) begin
			case (ctl.op)
				OP_SIN_SQ: x2_q <= prod[32:16];
				OP_SIN_C1: t_q  <= 17'd42047 - prod[32:16];
				OP_SIN_C2: t_q  <= 17'd102944 - prod[32:16];
				OP_SIN_R:  sin_q[ctl.sel] <= sine_mag(prod[34:16], arg[17]);
				OP_FX:     fx_q <= VEC_W'(rnd_vec(prod));
				OP_FZ:     fz_q <= VEC_W'(rnd_vec(prod));
				OP_UX:     ux_q <= VEC_W'(-rnd_vec(prod));
				OP_UZ:     uz_q <= VEC_W'(rnd_vec(prod));
				OP_UY_A:   acc_q <= prod;
				OP_UY_B:   uy_q <= VEC_W'(rnd_vec(acc_q - prod));
				OP_STEP:   step_q <= prod[31:0];
				OP_D_FX:   d_fx_q <= DELTA_W'(rnd_vec(prod));
				OP_D_FY:   d_fy_q <= DELTA_W'(rnd_vec(prod));
				OP_D_FZ:   d_fz_q <= DELTA_W'(rnd_vec(prod));
				OP_D_RX:   d_rx_q <= DELTA_W'(rnd_vec(prod));
				OP_D_RZ:   d_rz_q <= DELTA_W'(rnd_vec(prod));
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.load_out)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out)
			m_axis_tdata <= {16'(uz_q), 16'(uy_q), 16'(ux_q),
				16'(fz_q), 16'(sp), 16'(fx_q), pos_z_q, pos_y_q, pos_x_q};
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

[src/flcu_checker.sv]
// Port-level checker for the camera update block, bound to the top level.
// Depends on flcu_pkg and free_look_camera_update.
module flcu_checker import flcu_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_W-1:0]      m_axis_tdata
);

	// drop input readiness for the frame being worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted frame");

	// a new result and renewed readiness appear together
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $rose(s_axis_tready))
		else $error("result shown without returning to idle");

	// hold valid under stall
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped under stall");

	// hold data under stall
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed under stall");

endmodule

bind free_look_camera_update flcu_checker u_flcu_checker (.*);

[test/testbench.sv]
// Testbench for free_look_camera_update: drives frames and config writes,
// predicts position, front and up vectors and checks every result.
// Depends on flcu_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
	import flcu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	free_look_camera_update DUT (.*);

	always #10 clk = ~clk;

	// packed from the top down: up_z in the highest bits, pos_x in the lowest
	typedef struct packed {
		logic [15:0] uz, uy, ux, fz, fy, fx;
		logic [31:0] pz, py, px;
	} pose_t;

	// camera model state
	logic [19:0] turn_spd;
	logic [15:0] move_spd;
	logic [23:0] yaw, pitch;
	logic signed [31:0] cam_x, cam_y, cam_z;

	logic [IN_W-1:0] frame_q[$];
	pose_t pose_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int cfg_total = 0;
	int gap_s = 0, gap_m = 0;
	bit hold_sender = 1'b0;

	function automatic longint rnd_half(longint v);
		// floor((v + 2^13) / 2^14); >>> on longint is a floor shift
		return (v + 64'sd8192) >>> 14;
	endfunction

	function automatic longint sin_q(logic [23:0] a);
		longint x, x2, t, r, m;
		x = a[21:0] >> 6;
		if (a[22]) x = 65536 - x;
		x2 = (x * x) >> 16;
		t = 42047 - ((x2 * 4639) >> 16);
		t = 102944 - ((x2 * t) >> 16);
		r = (x * t) >> 16;
		m = (r + 2) >>> 2;
		return a[23] ? -m : m;
	endfunction

	function automatic logic signed [31:0] clamp_add(logic signed [31:0] p, longint d);
		longint s;
		s = longint'(p) + d;
		if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (s < -64'sd2147483648) return 32'sh80000000;
		return 32'(s);
	endfunction

	// advance the camera by one frame and return the expected pose
	function automatic pose_t camera_step(logic [IN_W-1:0] d);
		longint dx, dy, sy, cy, sp, cp, fx, fy, fz, rx, rz, ux, uy, uz, stp;
		pose_t p;
		dx = longint'($signed(d[11:0]));
		dy = longint'($signed(d[23:12]));
		yaw = 24'(longint'(yaw) + dx * longint'(turn_spd));
		pitch = 24'(longint'(pitch) + dy * longint'(turn_spd));
		sy = sin_q(yaw);
		cy = sin_q(yaw + QUARTER);
		sp = sin_q(pitch);
		cp = sin_q(pitch + QUARTER);
		fx = rnd_half(cy * cp);
		fy = sp;
		fz = rnd_half(sy * cp);
		rx = (cp < 0) ? sy : -sy;
		rz = (cp < 0) ? -cy : cy;
		ux = -rnd_half(rz * fy);
		uy = rnd_half(rz * fx - rx * fz);
		uz = rnd_half(rx * fy);
		stp = longint'(move_spd) * longint'(d[39:24]);
		if (d[40]) begin
			cam_x = clamp_add(cam_x, rnd_half(fx * stp));
			cam_y = clamp_add(cam_y, rnd_half(fy * stp));
			cam_z = clamp_add(cam_z, rnd_half(fz * stp));
		end
		if (d[41]) begin
			cam_x = clamp_add(cam_x, -rnd_half(rx * stp));
			cam_z = clamp_add(cam_z, -rnd_half(rz * stp));
		end
		if (d[42]) begin
			cam_x = clamp_add(cam_x, -rnd_half(fx * stp));
			cam_y = clamp_add(cam_y, -rnd_half(fy * stp));
			cam_z = clamp_add(cam_z, -rnd_half(fz * stp));
		end
		if (d[43]) begin
			cam_x = clamp_add(cam_x, rnd_half(rx * stp));
			cam_z = clamp_add(cam_z, rnd_half(rz * stp));
		end
		p.px = cam_x; p.py = cam_y; p.pz = cam_z;
		p.fx = 16'(fx); p.fy = 16'(fy); p.fz = 16'(fz);
		p.ux = 16'(ux); p.uy = 16'(uy); p.uz = 16'(uz);
		return p;
	endfunction

	function automatic logic [IN_W-1:0] pack_frame(int dx, int dy, int et, logic [3:0] keys);
		return {4'b0, keys, 16'(et), 12'(dy), 12'(dx)};
	endfunction

	function automatic logic [IN_W-1:0] rand_frame();
		logic [IN_W-1:0] f;
		f = IN_W'({$urandom, $urandom});
		f[47:44] = 4'($urandom);   // unused bits, ignored by the block
		case ($urandom_range(0, 3))
			0: f[39:24] = 16'($urandom_range(0, 100));
			1: f[11:0] = 12'($urandom_range(0, 40) - 20);
			default: ;
		endcase
		return f;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) != 0) return 0;
		if ($urandom_range(0, 9) != 0) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	task automatic camera_step_push(logic [IN_W-1:0] d);
		pose_q.push_back(camera_step(d));
	endtask

	// Driver: present queued frames; hold each until the transaction completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				camera_step_push(s_axis_tdata);
				gap_s = gap_len();
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// keep presenting
			end else if (gap_s > 0 || hold_sender || frame_q.size() == 0) begin
				if (gap_s > 0) gap_s--;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= frame_q.pop_front();
			end
		end
	end

	// Monitor: random backpressure, compare each result with the oldest pose.
	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pose_q.size() == 0) begin
					$error("result with no frame pending");
					errors++;
				end else begin
					want = pose_q.pop_front();
					if (got.px != want.px) begin $error("pos_x exp %h got %h", want.px, got.px); errors++; end
					if (got.py != want.py) begin $error("pos_y exp %h got %h", want.py, got.py); errors++; end
					if (got.pz != want.pz) begin $error("pos_z exp %h got %h", want.pz, got.pz); errors++; end
					if (got.fx != want.fx) begin $error("front_x exp %h got %h", want.fx, got.fx); errors++; end
					if (got.fy != want.fy) begin $error("front_y exp %h got %h", want.fy, got.fy); errors++; end
					if (got.fz != want.fz) begin $error("front_z exp %h got %h", want.fz, got.fz); errors++; end
					if (got.ux != want.ux) begin $error("up_x exp %h got %h", want.ux, got.ux); errors++; end
					if (got.uy != want.uy) begin $error("up_y exp %h got %h", want.uy, got.uy); errors++; end
					if (got.uz != want.uz) begin $error("up_z exp %h got %h", want.uz, got.uz); errors++; end
				end
			end
			if (gap_m > 0) begin
				gap_m--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (m_axis_tvalid && m_axis_tready) gap_m = gap_len();
			end
			if (idle_cycles >= 20000) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Wait until the driver has drained its queue and every pose has arrived.
	task automatic drain();
		while (frame_q.size() != 0 || s_axis_tvalid || pose_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Write one register while the block is idle; the model follows.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_TURN_SPEED) turn_spd = val;
		else if (idx == REG_MOVE_SPEED) move_spd = val[15:0];
		cfg_total++;
	endtask

	initial begin
		int k;
		turn_spd = 20'd9321; move_spd = 16'd1311;
		yaw = YAW_RESET; pitch = '0;
		cam_x = 0; cam_y = 0; cam_z = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each key alone, all keys, vertical pitch
		frame_q.push_back(pack_frame(0, 0, 0, 4'b0000));
		frame_q.push_back(pack_frame(2047, 0, 65535, 4'b0001));
		frame_q.push_back(pack_frame(-2048, 0, 65535, 4'b0010));
		frame_q.push_back(pack_frame(0, 2047, 65535, 4'b0100));
		frame_q.push_back(pack_frame(0, -2048, 65535, 4'b1000));
		frame_q.push_back(pack_frame(1, -1, 1, 4'b1111));
		frame_q.push_back(pack_frame(0, 0, 65535, 4'b0101));
		frame_q.push_back(pack_frame(0, 0, 65535, 4'b1010));
		drain();
		// pitch exactly vertical: quarter circle needs turn_speed 2^22 / count
		write_reg(REG_TURN_SPEED, 20'd1 << 19);
		write_reg(REG_MOVE_SPEED, 16'hFFFF);
		write_reg(8'd7, 20'hABCDE);   // out-of-range index, dropped
		frame_q.push_back(pack_frame(0, 8, 100, 4'b1111));
		frame_q.push_back(pack_frame(3, 8, 200, 4'b0011));
		frame_q.push_back(pack_frame(0, -8, 300, 4'b1100));
		// drive position into saturation on every axis
		for (k = 0; k < 8; k++) frame_q.push_back(pack_frame(k, k * 3, 65535, 4'(k + 1)));
		for (k = 0; k < 8; k++) frame_q.push_back(pack_frame(-k, k, 65535, 4'(~k)));
		drain();

		// random phases under several settings, extremes included
		for (k = 0; k < 6; k++) begin
			case (k)
				0: begin write_reg(REG_TURN_SPEED, 20'd0); write_reg(REG_MOVE_SPEED, 16'd0); end
				1: begin write_reg(REG_TURN_SPEED, 20'hFFFFF); write_reg(REG_MOVE_SPEED, 16'hFFFF); end
				2: begin write_reg(REG_TURN_SPEED, 20'd9321); write_reg(REG_MOVE_SPEED, 16'd1311); end
				default: begin
					write_reg(REG_TURN_SPEED, 20'($urandom));
					write_reg(REG_MOVE_SPEED, 16'($urandom));
				end
			endcase
			repeat (210) frame_q.push_back(rand_frame());
			if (k == 3) begin
				// pause the sender until every result is back
				while (frame_q.size() > 100) @(posedge clk);
				hold_sender = 1'b1;
				while (s_axis_tvalid || pose_q.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end

		if (errors == 0 && pose_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
